// File: rtl/sst_pkg.sv
// shared types and constants for the swap slot table
`timescale 1ns / 1ps

package sst_pkg;

    // fixed field widths
    localparam int OWNER_W          = 16;
    localparam int ADDR_W           = 32;
    localparam int PAGE_SHIFT       = 12;
    localparam int PAGE_W           = ADDR_W - PAGE_SHIFT;
    localparam int SLOT_W           = 10;
    localparam int SECTOR_W         = 13;
    localparam int COUNT_W          = 11;
    localparam int SECTORS_PER_SLOT = 8;

    // operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_REPLY
    } state_t;

    // owner and page stored per slot
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [PAGE_W-1:0]  page;
    } tag_t;

endpackage

// File: rtl/sst_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sst_match.sv
// slot compare unit shared by the allocate and lookup scans
`timescale 1ns / 1ps

module sst_match (
    input  logic          lookup,
    input  logic          entry_used,
    input  sst_pkg::tag_t entry_tag,
    input  sst_pkg::tag_t key,
    output logic          hit
);

    import sst_pkg::*;

    logic tag_eq;

    // free slot for allocate, used slot with equal owner and page for lookup
    always_comb begin
        tag_eq = (entry_tag.owner == key.owner) && (entry_tag.page == key.page);
        if (lookup) begin
            hit = entry_used && tag_eq;
        end else begin
            hit = !entry_used;
        end
    end

endmodule

// File: rtl/swap_slot_table.sv
// swap slot table: first-free slot allocator with release and owner/page lookup
`timescale 1ns / 1ps
//
//  channel   dir  handshake              payload (low bit first)
//  s_        in   s_tvalid / s_tready    tuser: op; tdata: owner_id, user_address, slot_index
//  m_        out  m_tvalid / m_tready    tuser: status; tdata: slot, sector_base
//  cfg_      in   cfg_valid / cfg_ready  cfg_data: slot_count
//
//  allocate and lookup probe one slot a cycle through the flag and tag rams and the
//  compare unit; a new beat is taken only once the result is loaded. Release, an
//  allocate with a zero count and unused codes skip the scan. After reset a clearing
//  pass writes every in-use flag with s_tready low; a held result lets the next beat
//  in but stalls its reply.

module swap_slot_table #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // owner_id, user_address, slot_index
    input  logic [1:0]                  s_tuser,   // op
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // slot, sector_base
    output logic [1:0]                  m_tuser,   // status
    // slot_count register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sst_pkg::COUNT_W-1:0] cfg_data
);

    import sst_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);

    state_t              st_reg, st_next;
    logic [COUNT_W-1:0]  slot_count_reg;
    op_t                 op_reg;
    tag_t                key_reg;
    logic [SLOT_W-1:0]   rel_idx_reg;
    logic [AW-1:0]       issue_addr_reg, issue_addr_next;
    logic                issue_on_reg, issue_on_next;
    logic [AW-1:0]       last_reg, last_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [AW-1:0]       chk_addr_reg, chk_addr_next;
    logic [AW-1:0]       highest_reg, highest_next;
    status_t             res_status_reg, res_status_next;
    logic [AW-1:0]       res_idx_reg, res_idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [23:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;
    logic                out_load;

    logic [31:0]         limit32;
    logic [31:0]         res_wide;
    logic                flag_we;
    logic [AW-1:0]       flag_waddr;
    logic                flag_wdata;
    logic                flag_rdata;
    logic                tag_we;
    tag_t                tag_rdata;
    logic                hit;

    // slot_count register, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= COUNT_W'(1024);
        end else if (cfg_valid) begin
            slot_count_reg <= cfg_data;
        end
    end

    // usable slots: smaller of slot_count and MAX_SLOTS
    assign limit32 = (32'(slot_count_reg) < 32'(MAX_SLOTS)) ? 32'(slot_count_reg)
                                                              : 32'(MAX_SLOTS);

    // latch the accepted beat
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg        <= op_t'(s_tuser);
            key_reg.owner <= s_tdata[15:0];
            key_reg.page  <= s_tdata[47:16+PAGE_SHIFT];
            rel_idx_reg   <= s_tdata[57:48];
        end
    end

    // in-use flags, cleared by the pass after reset
    sst_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (issue_addr_reg),
        .rdata (flag_rdata)
    );

    // owner and page tags
    sst_ram #(
        .WIDTH ($bits(tag_t)),
        .DEPTH (MAX_SLOTS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (chk_addr_reg),
        .wdata (key_reg),
        .raddr (issue_addr_reg),
        .rdata (tag_rdata)
    );

    // shared slot compare
    sst_match u_match (
        .lookup     (op_reg == OP_LOOKUP),
        .entry_used (flag_rdata),
        .entry_tag  (tag_rdata),
        .key        (key_reg),
        .hit        (hit)
    );

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= S_CLEAR;
            issue_addr_reg <= '0;
            issue_on_reg   <= 1'b0;
            chk_valid_reg  <= 1'b0;
            highest_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            st_reg         <= st_next;
            issue_addr_reg <= issue_addr_next;
            issue_on_reg   <= issue_on_next;
            chk_valid_reg  <= chk_valid_next;
            highest_reg    <= highest_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // scan and result payload
    always_ff @(posedge aclk) begin
        last_reg       <= last_next;
        chk_addr_reg   <= chk_addr_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
    end

    // next state and ram controls
    always_comb begin
        st_next         = st_reg;
        issue_addr_next = issue_addr_reg;
        issue_on_next   = issue_on_reg;
        last_next       = last_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = issue_addr_reg;
        highest_next    = highest_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        flag_we         = 1'b0;
        flag_waddr      = chk_addr_reg;
        flag_wdata      = 1'b0;
        tag_we          = 1'b0;
        out_load        = 1'b0;
        s_tready        = 1'b0;

        unique case (st_reg)
            S_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = issue_addr_reg;
                if (issue_addr_reg == AW'(MAX_SLOTS - 1)) begin
                    issue_addr_next = '0;
                    st_next         = S_IDLE;
                end else begin
                    issue_addr_next = issue_addr_reg + AW'(1);
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    st_next = S_DECODE;
                end
            end
            S_DECODE: begin
                issue_addr_next = '0;
                res_idx_next    = '0;
                unique case (op_reg)
                    OP_ALLOC: begin
                        if (limit32 == 32'd0) begin
                            res_status_next = ST_FULL;
                            st_next         = S_REPLY;
                        end else begin
                            last_next     = AW'(limit32 - 32'd1);
                            issue_on_next = 1'b1;
                            st_next       = S_SCAN;
                        end
                    end
                    OP_LOOKUP: begin
                        last_next     = highest_reg;
                        issue_on_next = 1'b1;
                        st_next       = S_SCAN;
                    end
                    OP_RELEASE: begin
                        if (32'(rel_idx_reg) >= limit32) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            flag_we         = 1'b1;
                            flag_waddr      = AW'(rel_idx_reg);
                            res_status_next = ST_OK;
                        end
                        st_next = S_REPLY;
                    end
                    default: begin
                        res_status_next = ST_RANGE;
                        st_next         = S_REPLY;
                    end
                endcase
            end
            S_SCAN: begin
                // issue one read a cycle up to the last slot
                if (issue_on_reg) begin
                    chk_valid_next = 1'b1;
                    if (issue_addr_reg == last_reg) begin
                        issue_on_next = 1'b0;
                    end else begin
                        issue_addr_next = issue_addr_reg + AW'(1);
                    end
                end
                // check the slot read last cycle
                if (chk_valid_reg) begin
                    if (hit) begin
                        res_status_next = ST_OK;
                        res_idx_next    = chk_addr_reg;
                        issue_on_next   = 1'b0;
                        chk_valid_next  = 1'b0;
                        st_next         = S_REPLY;
                        if (op_reg == OP_ALLOC) begin
                            flag_we    = 1'b1;
                            flag_wdata = 1'b1;
                            tag_we     = 1'b1;
                            if (chk_addr_reg > highest_reg) begin
                                highest_next = chk_addr_reg;
                            end
                        end
                    end else if (chk_addr_reg == last_reg) begin
                        res_status_next = (op_reg == OP_ALLOC) ? ST_FULL : ST_MISS;
                        chk_valid_next  = 1'b0;
                        st_next         = S_REPLY;
                    end
                end
            end
            S_REPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    st_next  = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    // output register
    assign res_wide = (res_status_reg == ST_OK) ? 32'(res_idx_reg) : 32'd0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {1'b0,
                            SECTOR_W'(res_wide * 32'(SECTORS_PER_SLOT)),
                            res_wide[SLOT_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // scan never checks past its last slot
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_SCAN && chk_valid_reg) |-> (chk_addr_reg <= last_reg))
        else $error("scan checked a slot past its bound");

    // an allocation leaves the highest mark at or above the slot taken
    a_highest: assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_we) |=> (highest_reg >= $past(chk_addr_reg)))
        else $error("highest mark below allocated slot");

    // a failed item reports slot and sector zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 24'd0))
        else $error("nonzero slot on a failed item");

    // no beat taken during the clearing pass
    a_clear_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_CLEAR) |-> (!s_tready && !tag_we))
        else $error("activity during clearing pass");

endmodule
